### rtl/awbd_pkg.sv
// Shared types and constants for the alpha-weighted box downscaler.
package awbd_pkg;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_LEVEL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CSUM_W = 21;
	localparam int unsigned ASUM_W = 12;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pix_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       image_done;
	} opix_t;

	// Finished block sums handed to the divide unit
	typedef struct packed {
		logic [CSUM_W-1:0] rs;
		logic [CSUM_W-1:0] gs;
		logic [CSUM_W-1:0] bs;
		logic [ASUM_W-1:0] as;
		logic [1:0]        ashift;
		logic              pass;
		logic              image_done;
	} blk_t;
endpackage

### rtl/awbd_if.sv
// Valid/ready stream and configuration interfaces.
interface awbd_pix_if;
	logic valid;
	logic ready;
	awbd_pkg::pix_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface awbd_opix_if;
	logic valid;
	logic ready;
	awbd_pkg::opix_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface awbd_cfg_if;
	logic valid;
	logic ready;
	logic [awbd_pkg::CFG_IDX_W-1:0] index;
	logic [awbd_pkg::CFG_DATA_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

### rtl/awbd_div.sv
// Sequential restoring divider for the three colour channels of one block.
module awbd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  awbd_pkg::blk_t     blk,
	output logic               busy,
	output logic               done,
	output awbd_pkg::opix_t    res
);
	localparam int unsigned NW = awbd_pkg::CSUM_W;
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] rq_q, gq_q, bq_q;
	logic [awbd_pkg::ASUM_W:0] rr_q, gr_q, br_q;
	logic [awbd_pkg::ASUM_W-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic run_q;
	awbd_pkg::blk_t b_q;

	logic [awbd_pkg::ASUM_W:0] rt, gt, bt;
	logic [awbd_pkg::ASUM_W:0] dx;

	assign dx = {1'b0, den_q};
	assign rt = {rr_q[awbd_pkg::ASUM_W-1:0], rq_q[NW-1]};
	assign gt = {gr_q[awbd_pkg::ASUM_W-1:0], gq_q[NW-1]};
	assign bt = {br_q[awbd_pkg::ASUM_W-1:0], bq_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= !blk.pass;
				done <= blk.pass;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			b_q <= blk;
			rq_q <= blk.rs;
			gq_q <= blk.gs;
			bq_q <= blk.bs;
			rr_q <= '0;
			gr_q <= '0;
			br_q <= '0;
			den_q <= blk.as;
		end else if (run_q) begin
			rq_q <= {rq_q[NW-2:0], rt >= dx};
			gq_q <= {gq_q[NW-2:0], gt >= dx};
			bq_q <= {bq_q[NW-2:0], bt >= dx};
			rr_q <= (rt >= dx) ? rt - dx : rt;
			gr_q <= (gt >= dx) ? gt - dx : gt;
			br_q <= (bt >= dx) ? bt - dx : bt;
		end
	end

	logic zero;
	logic [awbd_pkg::ASUM_W-1:0] amean;
	assign zero = (b_q.as == '0);
	// divide by f*f: shift by twice log2 of the factor
	assign amean = b_q.as >> {b_q.ashift, 1'b0};
	assign busy = run_q;

	always_comb begin
		res.image_done = b_q.image_done;
		if (b_q.pass) begin
			res.red = b_q.rs[7:0];
			res.green = b_q.gs[7:0];
			res.blue = b_q.bs[7:0];
			res.alpha = b_q.as[7:0];
		end else begin
			res.red = zero ? 8'd0 : rq_q[7:0];
			res.green = zero ? 8'd0 : gq_q[7:0];
			res.blue = zero ? 8'd0 : bq_q[7:0];
			res.alpha = amean[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (arst_n && start)
			assert (!run_q) else $error("divider restarted while busy");
	end
	ap_done_once: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held two cycles");
	ap_busy_nodone: assert property (@(posedge clk) disable iff (!arst_n) run_q |-> !done)
		else $error("done while busy");
endmodule

### rtl/awbd_accum.sv
// Line-memory accumulator: read, add, write back one column-block sum per pixel.
module awbd_accum #(
	parameter int unsigned DEPTH = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  awbd_pkg::pix_t       pix,
	input  logic [$clog2(DEPTH)-1:0] idx,
	input  logic                 first,
	input  logic                 last,
	input  logic                 pass,
	input  logic                 keep,
	input  logic                 image_done,
	input  logic [1:0]           ashift,
	output logic                 blk_valid,
	output awbd_pkg::blk_t       blk
);
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned MW = 3 * awbd_pkg::CSUM_W + awbd_pkg::ASUM_W;

	logic [MW-1:0] mem [DEPTH];
	logic [MW-1:0] rd_s2;

	logic go_s2, first_s2, last_s2, pass_s2, keep_s2, done_s2;
	logic [1:0] ash_s2;
	logic [AW-1:0] idx_s2;
	awbd_pkg::pix_t pix_s2;
	logic [awbd_pkg::CSUM_W-1:0] pr_s2, pg_s2, pb_s2;

	always_ff @(posedge clk) begin
		rd_s2 <= mem[idx];
		idx_s2 <= idx;
		pix_s2 <= pix;
		first_s2 <= first;
		last_s2 <= last;
		pass_s2 <= pass;
		keep_s2 <= keep;
		done_s2 <= image_done;
		ash_s2 <= ashift;
		pr_s2 <= awbd_pkg::CSUM_W'(pix.red * pix.alpha);
		pg_s2 <= awbd_pkg::CSUM_W'(pix.green * pix.alpha);
		pb_s2 <= awbd_pkg::CSUM_W'(pix.blue * pix.alpha);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) go_s2 <= 1'b0;
		else go_s2 <= go;
	end

	logic [awbd_pkg::CSUM_W-1:0] or_, og, ob;
	logic [awbd_pkg::ASUM_W-1:0] oa;
	assign {or_, og, ob, oa} = first_s2 ? '0 : rd_s2;

	awbd_pkg::blk_t nb;
	always_comb begin
		nb.rs = or_ + pr_s2;
		nb.gs = og + pg_s2;
		nb.bs = ob + pb_s2;
		nb.as = oa + awbd_pkg::ASUM_W'(pix_s2.alpha);
		nb.ashift = ash_s2;
		nb.pass = pass_s2;
		nb.image_done = done_s2;
		if (pass_s2) begin
			nb.rs = awbd_pkg::CSUM_W'(pix_s2.red);
			nb.gs = awbd_pkg::CSUM_W'(pix_s2.green);
			nb.bs = awbd_pkg::CSUM_W'(pix_s2.blue);
			nb.as = awbd_pkg::ASUM_W'(pix_s2.alpha);
		end
	end

	// write back; sequential issue keeps reads of an entry behind its last write
	always_ff @(posedge clk) begin
		if (go_s2 && keep_s2 && !pass_s2)
			mem[idx_s2] <= {nb.rs, nb.gs, nb.bs, nb.as};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) blk_valid <= 1'b0;
		else blk_valid <= go_s2 && (pass_s2 || (keep_s2 && last_s2));
	end
	always_ff @(posedge clk) blk <= nb;

	ap_valid_after_go: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid |-> $past(go_s2)) else $error("block without pixel");
	ap_go_sep: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> !go) else $error("back-to-back issue overlaps memory access");
endmodule

### rtl/alpha_weighted_box_downscale.sv
// Top level of the alpha-weighted box downscaler.
// Each accepted word holds the input off while it passes issue, memory read, add and
// write back until its slot reopens, so words enter one at a time.
// A finished block runs the serial divider, and its result word is registered at the output
// (pass-through words skip the divide). The input holds off while the divider runs, a result
// word waits or a configuration write is offered. Reset clears position, control and
// registers (scale 3, width 1, height 1); the line memory holds no reset value.
module alpha_weighted_box_downscale #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic clk,
	input  logic arst_n,
	awbd_cfg_if.sink   cfg,
	awbd_pix_if.sink   pix_in,
	awbd_opix_if.source pix_out
);
	localparam int unsigned DEPTH = MAX_WIDTH / 2;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

	logic [2:0]  scale_q;
	logic [12:0] width_q;
	logic [15:0] height_q;
	logic [15:0] col_q, row_q;

	assign cfg.ready = 1'b1;

	// effective sizes
	logic [WW-1:0] w;
	logic [15:0] h;
	always_comb begin
		if (width_q == '0) w = WW'(1);
		else if (32'(width_q) > MAX_WIDTH) w = WW'(MAX_WIDTH);
		else w = WW'(width_q);
		h = (height_q == '0) ? 16'd1 : height_q;
	end

	logic [1:0] sh;  // log2 of factor
	always_comb begin
		case (scale_q)
			3'd1: sh = 2'd2;
			3'd2: sh = 2'd1;
			default: sh = 2'd0;
		endcase
	end

	logic [15:0] col, row, fmask, wf, hf;
	always_comb begin
		col = (col_q >= 16'(w)) ? 16'(w) - 16'd1 : col_q;
		row = (row_q >= h) ? h - 16'd1 : row_q;
		fmask = (16'd1 << sh) - 16'd1;
		wf = 16'(w) & ~fmask;
		hf = h & ~fmask;
	end

	logic pass, keep, first, last, idone;
	always_comb begin
		pass = (sh == 2'd0) || (wf == 16'd0) || (hf == 16'd0);
		keep = (col < wf) && (row < hf);
		first = ((col & fmask) == 16'd0) && ((row & fmask) == 16'd0);
		last = ((col & fmask) == fmask) && ((row & fmask) == fmask);
		if (pass) idone = (col == 16'(w) - 16'd1) && (row == h - 16'd1);
		else idone = ((col >> sh) == (wf >> sh) - 16'd1)
			&& ((row >> sh) == (hf >> sh) - 16'd1);
	end

	// control: one word in flight through the line memory and divider
	logic [2:0] gap_q;
	logic out_v_q, div_busy, div_done, blk_v;
	logic accept;
	awbd_pkg::blk_t blk;
	awbd_pkg::opix_t dres;

	assign pix_in.ready = (gap_q == '0) && !div_busy && !out_v_q && !cfg.valid;
	assign accept = pix_in.valid && pix_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 3'd3;
			width_q <= 13'd1;
			height_q <= 16'd1;
			col_q <= '0;
			row_q <= '0;
			gap_q <= '0;
		end else begin
			if (gap_q != '0) gap_q <= gap_q - 1'b1;
			if (accept) begin
				// hold off until sums and possible divider start settle
				gap_q <= 3'd4;
				if (col + 16'd1 >= 16'(w)) begin
					col_q <= '0;
					row_q <= (row + 16'd1 >= h) ? 16'd0 : row + 16'd1;
				end else begin
					col_q <= col + 16'd1;
					row_q <= row;
				end
			end
			if (cfg.valid) begin
				case (cfg.index)
					awbd_pkg::REG_SCALE_LEVEL: scale_q <= cfg.wdata[2:0];
					awbd_pkg::REG_IMAGE_WIDTH: width_q <= cfg.wdata[12:0];
					awbd_pkg::REG_IMAGE_HEIGHT: height_q <= cfg.wdata;
					default: ;
				endcase
				if (cfg.index inside {awbd_pkg::REG_SCALE_LEVEL, awbd_pkg::REG_IMAGE_WIDTH,
					awbd_pkg::REG_IMAGE_HEIGHT}) begin
					col_q <= '0;
					row_q <= '0;
				end
			end
		end
	end

	awbd_accum #(.DEPTH(DEPTH)) u_accum (
		.clk(clk), .arst_n(arst_n), .go(accept), .pix(pix_in.data),
		.idx(AW'(col >> sh)), .first(first), .last(last), .pass(pass),
		.keep(keep), .image_done(idone), .ashift(sh),
		.blk_valid(blk_v), .blk(blk)
	);

	awbd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(blk_v), .blk(blk),
		.busy(div_busy), .done(div_done), .res(dres)
	);

	// output register holds the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (div_done) out_v_q <= 1'b1;
		else if (pix_out.ready) out_v_q <= 1'b0;
	end
	always_ff @(posedge clk) if (div_done) pix_out.data <= dres;
	assign pix_out.valid = out_v_q;

	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !accept) else $error("accepted while dividing");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !pix_out.ready) |=> out_v_q) else $error("result dropped");
	ap_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> !out_v_q) else $error("result overwritten");
endmodule

### test/awbd_downscale_checker.sv
// Scoreboard for the downscaler: tracks registers, predicts result words, compares them.
`timescale 1ns / 1ps
module awbd_downscale_checker #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic clk,
	input  logic arst_n,
	awbd_cfg_if  cfg,
	awbd_pix_if  pix_in,
	awbd_opix_if pix_out,
	output int   fail_count,
	output int   pending
);
	localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;

	logic [2:0]  level;
	logic [12:0] width;
	logic [15:0] height;
	logic [awbd_pkg::CSUM_W-1:0] red_line [LINE_DEPTH];
	logic [awbd_pkg::CSUM_W-1:0] green_line [LINE_DEPTH];
	logic [awbd_pkg::CSUM_W-1:0] blue_line [LINE_DEPTH];
	logic [awbd_pkg::ASUM_W-1:0] alpha_line [LINE_DEPTH];
	int unsigned col_pos;
	int unsigned row_pos;
	awbd_pkg::opix_t expected_pixels[$];

	function automatic int unsigned shrink_factor(logic [2:0] lvl);
		if (lvl == 3'd1)
			return 4;
		if (lvl == 3'd2)
			return 2;
		return 1;
	endfunction

	// Advance the position by one source word and queue the result it finishes.
	task automatic accumulate_pixel(input awbd_pkg::pix_t p);
		int unsigned w, h, f, c, r, nw, nh, idx;
		logic [awbd_pkg::ASUM_W-1:0] asum;
		awbd_pkg::opix_t o;
		w = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
		h = (height == 0) ? 1 : height;
		f = shrink_factor(level);
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = (row_pos >= h) ? h - 1 : row_pos;
		if (f == 1 || w < f || h < f) begin
			o.red = p.red;
			o.green = p.green;
			o.blue = p.blue;
			o.alpha = p.alpha;
			o.image_done = (c == w - 1 && r == h - 1);
			expected_pixels.push_back(o);
		end else begin
			nw = w / f;
			nh = h / f;
			if (c < nw * f && r < nh * f) begin
				idx = (c / f) % LINE_DEPTH;
				if (c % f == 0 && r % f == 0) begin
					red_line[idx] = '0;
					green_line[idx] = '0;
					blue_line[idx] = '0;
					alpha_line[idx] = '0;
				end
				red_line[idx] = red_line[idx] + p.red * p.alpha;
				green_line[idx] = green_line[idx] + p.green * p.alpha;
				blue_line[idx] = blue_line[idx] + p.blue * p.alpha;
				alpha_line[idx] = alpha_line[idx] + p.alpha;
				if (c % f == f - 1 && r % f == f - 1) begin
					asum = alpha_line[idx];
					o.red = (asum != 0) ? 8'(red_line[idx] / asum) : 8'd0;
					o.green = (asum != 0) ? 8'(green_line[idx] / asum) : 8'd0;
					o.blue = (asum != 0) ? 8'(blue_line[idx] / asum) : 8'd0;
					o.alpha = 8'(asum / (f * f));
					o.image_done = (c / f == nw - 1 && r / f == nh - 1);
					expected_pixels.push_back(o);
				end
			end
		end
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		awbd_pkg::opix_t want;
		if (!arst_n) begin
			level = 3'd3;
			width = 13'd1;
			height = 16'd1;
			col_pos = 0;
			row_pos = 0;
			expected_pixels.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// Check the result word first: it never stems from a word taken at this edge.
			if (pix_out.valid && pix_out.ready) begin
				if (expected_pixels.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result word with nothing expected: %p", $time,
							pix_out.data);
				end else begin
					want = expected_pixels.pop_front();
					if (pix_out.data !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch exp r%0d g%0d b%0d a%0d d%0b got r%0d g%0d b%0d a%0d d%0b",
								$time, want.red, want.green, want.blue, want.alpha,
								want.image_done, pix_out.data.red, pix_out.data.green,
								pix_out.data.blue, pix_out.data.alpha,
								pix_out.data.image_done);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					awbd_pkg::REG_SCALE_LEVEL: begin
						level = cfg.wdata[2:0];
						col_pos = 0;
						row_pos = 0;
					end
					awbd_pkg::REG_IMAGE_WIDTH: begin
						width = cfg.wdata[12:0];
						col_pos = 0;
						row_pos = 0;
					end
					awbd_pkg::REG_IMAGE_HEIGHT: begin
						height = cfg.wdata[15:0];
						col_pos = 0;
						row_pos = 0;
					end
					default: ;
				endcase
			end
			if (pix_in.valid && pix_in.ready)
				accumulate_pixel(pix_in.data);
			pending = expected_pixels.size();
		end
	end
endmodule

### test/tb.sv
// Top of the downscaler testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
	// Scale level codes as the block decodes them
	localparam logic [2:0] LVL_NONE = 3'd0;
	localparam logic [2:0] LVL_QUAD = 3'd1;
	localparam logic [2:0] LVL_HALF = 3'd2;
	localparam logic [2:0] LVL_PASS = 3'd3;
	localparam logic [2:0] LVL_TOP = 3'd7;
	// Index past the register list; the block must ignore it
	localparam logic [awbd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned MAX_WIDTH = 4096;
	localparam int RANDOM_ITEMS = 1050;
	// Divider plus pipeline, with margin, for words that produce no result
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   hold_request = 0;
	int   hold_left = 0;
	int   random_sent = 0;

	awbd_cfg_if  cfg_bus ();
	awbd_pix_if  src_bus ();
	awbd_opix_if res_bus ();

	alpha_weighted_box_downscale #(.MAX_WIDTH(MAX_WIDTH)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.pix_in  (src_bus),
		.pix_out (res_bus)
	);

	awbd_downscale_checker #(.MAX_WIDTH(MAX_WIDTH)) scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_bus),
		.pix_in     (src_bus),
		.pix_out    (res_bus),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Guard against a hang anywhere in the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** alpha_weighted_box_downscale: FAILED **");
			$finish;
		end
	end

	// Result side: random stalls, or a long hold-off when the stimulus asks for one.
	initial res_bus.ready = 1'b0;
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			res_bus.ready <= 1'b0;
			hold_left--;
		end else begin
			res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Pick one of the four flow-control phases.
	task automatic set_flow(input int phase);
		case (phase % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
			default: begin send_idle_pct = 26; recv_stall_pct = 26; end
		endcase
	endtask

	// Hold until every expected result has come back; called at a falling edge.
	task automatic drain_results();
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [awbd_pkg::CFG_IDX_W-1:0] idx,
		input logic [15:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.wdata <= data;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Reprogram only once the block is idle; dropped words may still be in flight.
	task automatic configure(input logic [2:0] lvl, input logic [12:0] w, input logic [15:0] h);
		src_bus.valid <= 1'b0;
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(awbd_pkg::REG_SCALE_LEVEL, {3'($urandom), 10'($urandom), lvl});
		write_reg(awbd_pkg::REG_IMAGE_WIDTH, {3'($urandom), w});
		write_reg(awbd_pkg::REG_IMAGE_HEIGHT, h);
	endtask

	// Offer one word; valid stays high afterwards so back-to-back words need no toggle.
	task automatic send_pixel(input awbd_pkg::pix_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			src_bus.valid <= 1'b0;
			@(negedge clk);
		end
		src_bus.valid <= 1'b1;
		src_bus.data <= p;
		@(posedge clk);
		while (!src_bus.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Lean on the alpha and colour extremes: zero weight and fully opaque both matter.
	function automatic awbd_pkg::pix_t random_pixel();
		awbd_pkg::pix_t p;
		p = awbd_pkg::pix_t'($urandom);
		case ($urandom_range(5))
			0: p.alpha = 8'd0;
			1: p.alpha = 8'd255;
			2: begin p.red = 8'd255; p.green = 8'd0; p.blue = 8'd255; end
			default: ;
		endcase
		return p;
	endfunction

	task automatic send_random(input int count, input bit counted);
		repeat (count) begin
			send_pixel(random_pixel());
			if (counted)
				random_sent++;
		end
	endtask

	function automatic int image_words(input int w, input int h);
		int we, he;
		we = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
		he = (h == 0) ? 1 : h;
		return we * he;
	endfunction

	initial begin
		int phase, w, h, lvl_pick, images;
		logic [2:0] lvl;
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = awbd_pkg::REG_SCALE_LEVEL;
		cfg_bus.wdata = '0;
		src_bus.valid = 1'b0;
		src_bus.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: 2x2 blocks with saturated, mixed and zero-alpha content.
		configure(LVL_HALF, 13'd2, 16'd2);
		send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
		send_pixel('{8'd0, 8'd0, 8'd0, 8'd255});
		send_pixel('{8'd255, 8'd0, 8'd128, 8'd1});
		send_pixel('{8'd1, 8'd2, 8'd3, 8'd0});
		// Zero alpha sum must force colour to zero
		repeat (4) send_pixel('{8'd255, 8'd255, 8'd255, 8'd0});
		// 4x4 fully opaque white: largest sums the block can see
		configure(LVL_QUAD, 13'd4, 16'd4);
		repeat (16) send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
		// Height zero acts as one; pass-through of the field extremes
		configure(LVL_PASS, 13'd3, 16'd0);
		send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
		send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
		send_pixel('{8'd0, 8'd255, 8'd0, 8'd255});
		// A write past the register list must leave the position alone
		configure(LVL_NONE, 13'd3, 16'd2);
		send_random(2, 1'b0);
		src_bus.valid <= 1'b0;
		drain_results();
		write_reg(REG_UNUSED, 16'hFFFF);
		send_random(4, 1'b0);

		// Width above the maximum clamps; a short start of the first line.
		configure(LVL_HALF, 13'd8191, 16'd2);
		send_random(8, 1'b0);
		// Tallest image, pass-through at the maximum width
		configure(LVL_PASS, 13'd4096, 16'd65535);
		send_random(6, 1'b0);

		// Random: mostly whole images with random content, some cut short.
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			set_flow(phase);
			lvl_pick = $urandom_range(9);
			if (lvl_pick < 4)
				lvl = LVL_QUAD;
			else if (lvl_pick < 8)
				lvl = LVL_HALF;
			else if (lvl_pick == 8)
				lvl = 3'($urandom_range(LVL_PASS, LVL_TOP));
			else
				lvl = LVL_NONE;
			w = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 14);
			h = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 10);
			configure(lvl, 13'(w), 16'(h));
			if (phase == 3) begin
				// Long hold-off on results while words keep coming, to back up the input
				send_idle_pct = 0;
				hold_request = 400;
			end
			images = $urandom_range(1, 2);
			repeat (images) begin
				send_random(image_words(w, h), 1'b1);
				if (phase % 5 == 2) begin
					src_bus.valid <= 1'b0;
					drain_results();
				end
			end
			// Noise: a partial image, abandoned by the next reconfiguration
			if ($urandom_range(7) == 0)
				send_random($urandom_range(1, image_words(w, h)), 1'b1);
			phase++;
		end

		src_bus.valid <= 1'b0;
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("** alpha_weighted_box_downscale: PASSED **");
		end else begin
			$display("** alpha_weighted_box_downscale: FAILED **");
		end
		$finish;
	end
endmodule
